// ===== hdl/bad_pkg.sv =====
// ---------------------------------------------------------------------------
// bad_pkg
// Shared constants and types of the bilinear ARGB downscaler.
// ---------------------------------------------------------------------------
package bad_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int DW = 9;
    localparam int PW = 24;

    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_DST_W = 3'd2;
    localparam logic [2:0] REG_DST_H = 3'd3;
    localparam logic [2:0] REG_X_STEP = 3'd4;
    localparam logic [2:0] REG_Y_STEP = 3'd5;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [31:0]   wdata;
        logic          re;
    } mem_req_t;
endpackage

// ===== hdl/bilinear_argb_downscaler.sv =====
// ---------------------------------------------------------------------------
// bilinear_argb_downscaler
// Frame-store bilinear ARGB32 downscaler.
// ---------------------------------------------------------------------------
// Input words on s_axis: tuser = req_type, tdata = src_pixel. A load word
// writes the pixel into the frame store and gives no output; the next word
// can follow at once. An emit word reads four neighbors from the single-port
// store, through S_RD and then S_ACC for each, and presents one m_axis word
// from the output register once S_OUT finds it free: tdata = dst_pixel,
// tlast = frame_end, tuser = size_error. The next word is taken once the
// block is back in S_IDLE. A size error skips the reads and presents its
// word the cycle after acceptance. The store port sets the rate.
// The output register holds while m_axis_tready is low; load words are still
// taken, while an emit word, or a finished emit, waits until the held word
// leaves. Reset clears counters, positions and the registers to their
// defaults; the frame store is undefined until loaded. Write configuration
// only while idle.
// ---------------------------------------------------------------------------
module bilinear_argb_downscaler
    import bad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // src_pixel[31:0]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // dst_pixel[31:0]
    output logic        m_axis_tlast,   // frame_end
    output logic        m_axis_tuser    // size_error
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_ACC  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    logic [DW-1:0] sw_reg, sh_reg, dw_reg, dh_reg;
    logic [PW-1:0] xs_reg, ys_reg, xp_reg, yp_reg;
    logic [AW-1:0] la_reg;
    logic [DW-1:0] col_reg, row_reg;
    state_t        st_reg;
    logic [2:0]    k_reg;
    logic          ov_reg, ol_reg, ou_reg, end_reg;
    logic [31:0]   od_reg;

    logic [DW-1:0] sw, sh, dw, dh;
    logic [DW-1:0] x0, y0, x1, y1;
    logic [7:0]    fx, fy;
    logic [8:0]    gx, gy;
    logic [16:0]   w_reg;
    logic [AW-1:0] rd_addr, ld_addr;
    logic [31:0]   rdata, blend;
    logic [17:0]   frame;
    mem_req_t      req;
    logic          acc_en, clr, out_free, accept, is_emit, size_err, ov_set;
    logic [DW-1:0] nx, ny;

    function automatic logic [DW-1:0] sat(input logic [DW-1:0] v, input logic [DW-1:0] m);
        if (v == '0) return DW'(1);
        if (v > m) return m;
        return v;
    endfunction

    assign sw = sat(sw_reg, DW'(MAX_WIDTH));
    assign sh = sat(sh_reg, DW'(MAX_HEIGHT));
    assign dw = sat(dw_reg, DW'(MAX_WIDTH));
    assign dh = sat(dh_reg, DW'(MAX_HEIGHT));
    assign frame = 18'(sw * sh);

    assign x0 = ({1'b0, xp_reg[23:16]} > sw - 1'b1) ? sw - 1'b1 : {1'b0, xp_reg[23:16]};
    assign y0 = ({1'b0, yp_reg[23:16]} > sh - 1'b1) ? sh - 1'b1 : {1'b0, yp_reg[23:16]};
    assign x1 = (x0 + 1'b1 > sw - 1'b1) ? sw - 1'b1 : x0 + 1'b1;
    assign y1 = (y0 + 1'b1 > sh - 1'b1) ? sh - 1'b1 : y0 + 1'b1;
    assign fx = xp_reg[15:8];
    assign fy = yp_reg[15:8];
    assign gx = 9'd256 - {1'b0, fx};
    assign gy = 9'd256 - {1'b0, fy};

    assign ny = k_reg[1] ? y1 : y0;
    assign nx = k_reg[0] ? x1 : x0;
    assign rd_addr = AW'(ny * sw + nx);
    assign ld_addr = (18'(la_reg) >= frame) ? '0 : la_reg;

    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (st_reg == S_IDLE) && (!s_axis_tuser || out_free);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign is_emit = s_axis_tuser;
    assign size_err = (dw_reg > sw_reg) || (dh_reg > sh_reg);
    assign ov_set = ((st_reg == S_IDLE) && accept && is_emit && size_err)
                 || ((st_reg == S_OUT) && out_free);

    always_comb
    begin
        req.we    = accept && !is_emit;
        req.addr  = (accept && !is_emit) ? ld_addr : rd_addr;
        req.wdata = s_axis_tdata;
        req.re    = (st_reg == S_RD);
    end

    assign clr    = accept;
    assign acc_en = (st_reg == S_ACC);

    bad_store u_store (.clk(clk), .req(req), .rdata(rdata));
    bad_blend u_blend (.clk(clk), .clr(clr), .acc(acc_en), .pix(rdata),
                       .weight(w_reg), .result(blend));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 9'd256; sh_reg <= 9'd256; dw_reg <= 9'd256; dh_reg <= 9'd256;
            xs_reg <= 24'hff00; ys_reg <= 24'hff00;
            xp_reg <= '0; yp_reg <= '0; la_reg <= '0;
            col_reg <= '0; row_reg <= '0;
            st_reg <= S_IDLE; k_reg <= '0; ov_reg <= 1'b0;
            w_reg <= '0; end_reg <= 1'b0;
            od_reg <= '0; ol_reg <= 1'b0; ou_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SRC_W:  sw_reg <= cfg_data[8:0];
                    REG_SRC_H:  sh_reg <= cfg_data[8:0];
                    REG_DST_W:  dw_reg <= cfg_data[8:0];
                    REG_DST_H:  dh_reg <= cfg_data[8:0];
                    REG_X_STEP: xs_reg <= cfg_data;
                    REG_Y_STEP: ys_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ov_set)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (accept && !is_emit)
                    begin
                        la_reg <= (18'(ld_addr) + 18'd1 >= frame) ? '0 : ld_addr + 1'b1;
                    end
                    else if (accept && size_err)
                    begin
                        od_reg <= '0; ol_reg <= 1'b0; ou_reg <= 1'b1;
                    end
                    else if (accept)
                    begin
                        k_reg <= '0;
                        st_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    case (k_reg[1:0])
                        2'd0: w_reg <= 17'(gx * gy);
                        2'd1: w_reg <= 17'({1'b0, fx} * gy);
                        2'd2: w_reg <= 17'(gx * {1'b0, fy});
                        default: w_reg <= 17'(fx * fy);
                    endcase
                    st_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (k_reg == 3'd3)
                    begin
                        st_reg <= S_OUT;
                    end
                    else
                    begin
                        st_reg <= S_RD;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        od_reg <= blend; ou_reg <= 1'b0;
                        end_reg <= 1'b0;
                        if (10'(col_reg) + 10'd1 < 10'(dw))
                        begin
                            col_reg <= col_reg + 1'b1;
                            xp_reg <= xp_reg + xs_reg;
                            ol_reg <= 1'b0;
                        end
                        else
                        begin
                            col_reg <= '0; xp_reg <= '0;
                            if (10'(row_reg) + 10'd1 < 10'(dh))
                            begin
                                row_reg <= row_reg + 1'b1;
                                yp_reg <= yp_reg + ys_reg;
                                ol_reg <= 1'b0;
                            end
                            else
                            begin
                                row_reg <= '0; yp_reg <= '0;
                                ol_reg <= 1'b1;
                                end_reg <= 1'b1;
                            end
                        end
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = ou_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0 && !m_axis_tlast))
        else $error("size error word not clean");
    a_end_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(end_reg) |-> (col_reg == '0 && row_reg == '0 && xp_reg == '0))
        else $error("frame end without wrap");
endmodule

// ===== hdl/bad_store.sv =====
// ---------------------------------------------------------------------------
// bad_store
// Single-port frame store with a registered read.
// ---------------------------------------------------------------------------
module bad_store
    import bad_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [31:0] rdata
);
    logic [31:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        else if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end
endmodule

// ===== hdl/bad_blend.sv =====
// ---------------------------------------------------------------------------
// bad_blend
// Accumulates weighted neighbor channels one neighbor per cycle in which acc is high.
// ---------------------------------------------------------------------------
module bad_blend
    import bad_pkg::*;
(
    input  logic        clk,
    input  logic        clr,
    input  logic        acc,
    input  logic [31:0] pix,
    input  logic [16:0] weight,
    output logic [31:0] result
);
    logic [24:0] sum_reg [4];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (clr)
            begin
                sum_reg[i] <= '0;
            end
            else if (acc)
            begin
                sum_reg[i] <= sum_reg[i] + 25'(pix[8*i +: 8] * weight);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            result[8*i +: 8] = sum_reg[i][23:16];
        end
    end
endmodule
